### sv/nnra_pkg.sv
`default_nettype none
package nnra_pkg;

  // Byte index width of both address outputs
  localparam int IDX_W = 26;

  // Register field widths
  localparam int DIM_REG_W = 13;
  localparam int REM_REG_W = 12;
  localparam int CH_REG_W  = 3;

  // Configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Parameter defaults
  localparam int MAX_DIM_DEF      = 4096;
  localparam int MAX_CHANNELS_DEF = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH     = 3'd0,
    REG_OUT_WIDTH    = 3'd1,
    REG_OUT_HEIGHT   = 3'd2,
    REG_CHANNELS     = 3'd3,
    REG_X_STEP_WHOLE = 3'd4,
    REG_X_STEP_REM   = 3'd5,
    REG_Y_STEP_WHOLE = 3'd6,
    REG_Y_STEP_REM   = 3'd7
  } cfg_reg_t;

  // Register values after clamping, as the address walker uses them
  typedef struct packed {
    logic [DIM_REG_W-1:0] iw;
    logic [DIM_REG_W-1:0] ow;
    logic [DIM_REG_W-1:0] oh;
    logic [CH_REG_W-1:0]  ch;
    logic [DIM_REG_W-1:0] xw;
    logic [REM_REG_W-1:0] xr;
    logic [DIM_REG_W-1:0] yw;
    logic [REM_REG_W-1:0] yr;
  } cfg_eff_t;

endpackage
`default_nettype wire

### sv/nnra_tick_if.sv
`default_nettype none
interface nnra_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

### sv/nnra_move_if.sv
`default_nettype none
interface nnra_move_if;
  logic                       valid;
  logic                       ready;
  logic [nnra_pkg::IDX_W-1:0] src_addr;
  logic [nnra_pkg::IDX_W-1:0] dst_addr;
  logic                       last_of_image;

  modport source (output valid, output src_addr, output dst_addr, output last_of_image,
                  input ready);
  modport sink   (input valid, input src_addr, input dst_addr, input last_of_image,
                  output ready);
endinterface
`default_nettype wire

### sv/nnra_cfg_if.sv
`default_nettype none
interface nnra_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nnra_pkg::CFG_IDX_W-1:0]  index;
  logic [nnra_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/nnra_cfg.sv
`default_nettype none
module nnra_cfg #(
  parameter int MAX_DIM      = nnra_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = nnra_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  nnra_cfg_if.sink           cfg,
  output nnra_pkg::cfg_eff_t eff
);

  localparam int DW = nnra_pkg::DIM_REG_W;
  localparam int RW = nnra_pkg::REM_REG_W;
  localparam int CW = nnra_pkg::CH_REG_W;

  // Caps in register width; a cap beyond the register range never bites
  localparam logic [DW-1:0] DIM_CAP = (MAX_DIM > (2**DW - 1)) ? {DW{1'b1}} : DW'(MAX_DIM);
  localparam logic [CW-1:0] CH_CAP  =
    (MAX_CHANNELS > (2**CW - 1)) ? {CW{1'b1}} : CW'(MAX_CHANNELS);

  logic [DW-1:0] in_width, out_width, out_height, x_step_whole, y_step_whole;
  logic [RW-1:0] x_step_rem, y_step_rem;
  logic [CW-1:0] channels;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width     <= DW'(1);
      out_width    <= DW'(1);
      out_height   <= DW'(1);
      channels     <= CW'(1);
      x_step_whole <= DW'(1);
      x_step_rem   <= '0;
      y_step_whole <= DW'(1);
      y_step_rem   <= '0;
    end else if (cfg.valid) begin
      unique case (nnra_pkg::cfg_reg_t'(cfg.index))
        nnra_pkg::REG_IN_WIDTH:     in_width     <= cfg.data;
        nnra_pkg::REG_OUT_WIDTH:    out_width    <= cfg.data;
        nnra_pkg::REG_OUT_HEIGHT:   out_height   <= cfg.data;
        nnra_pkg::REG_CHANNELS:     channels     <= cfg.data[CW-1:0];
        nnra_pkg::REG_X_STEP_WHOLE: x_step_whole <= cfg.data;
        nnra_pkg::REG_X_STEP_REM:   x_step_rem   <= cfg.data[RW-1:0];
        nnra_pkg::REG_Y_STEP_WHOLE: y_step_whole <= cfg.data;
        nnra_pkg::REG_Y_STEP_REM:   y_step_rem   <= cfg.data[RW-1:0];
      endcase
    end
  end

  function automatic logic [DW-1:0] dim_clamp(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0)            r = DW'(1);
    else if (v > DIM_CAP)   r = DIM_CAP;
    else                    r = v;
    return r;
  endfunction

  always_comb begin
    eff.iw = dim_clamp(in_width);
    eff.ow = dim_clamp(out_width);
    eff.oh = dim_clamp(out_height);
    if (channels == '0)         eff.ch = CW'(1);
    else if (channels > CH_CAP) eff.ch = CH_CAP;
    else                        eff.ch = channels;
    eff.xw = (x_step_whole > DIM_CAP) ? DIM_CAP : x_step_whole;
    eff.yw = (y_step_whole > DIM_CAP) ? DIM_CAP : y_step_whole;
    // remainder at or above its divisor is taken as divisor minus one
    eff.xr = (DW'(x_step_rem) >= eff.ow) ? RW'(eff.ow - DW'(1)) : x_step_rem;
    eff.yr = (DW'(y_step_rem) >= eff.oh) ? RW'(eff.oh - DW'(1)) : y_step_rem;
  end

endmodule
`default_nettype wire

### sv/nnra_walk.sv
`default_nettype none
module nnra_walk #(
  parameter int MAX_DIM      = nnra_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = nnra_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nnra_pkg::cfg_eff_t eff,
  nnra_tick_if.sink               tick,
  nnra_move_if.source             move
);

  localparam int IW    = nnra_pkg::IDX_W;
  localparam int DW    = nnra_pkg::DIM_REG_W;
  localparam int RW    = nnra_pkg::REM_REG_W;
  localparam int CHW   = nnra_pkg::CH_REG_W;
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CC_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  // compare width covering counters and dimensions plus one
  localparam int CMP_W = ((CNT_W > DW) ? CNT_W : DW) + 1;

  // walk position
  logic [CNT_W-1:0] out_col, out_row, src_col_rem, src_row_rem;
  logic [CC_W-1:0]  chan_count;
  logic [IW-1:0]    src_col, src_row_base, dst_count;

  logic [CNT_W-1:0] out_col_next, out_row_next, src_col_rem_next, src_row_rem_next;
  logic [CC_W-1:0]  chan_count_next;
  logic [IW-1:0]    src_col_next, src_row_base_next, dst_count_next;

  // position after an optional restart
  logic [CNT_W-1:0] c_out_col, c_out_row, c_col_rem, c_row_rem;
  logic [CC_W-1:0]  c_chan;
  logic [IW-1:0]    c_src_col, c_row_base, c_dst;

  logic             end_chan, end_col, end_row;
  logic [CNT_W:0]   x_add, y_add;
  logic [IW-1:0]    row_step, src_pix, src_idx;
  logic             accept;

  // remainder step: returns {carry, new remainder}
  function automatic logic [CNT_W:0] rem_add(input logic [CNT_W-1:0] acc,
                                             input logic [RW-1:0] r,
                                             input logic [DW-1:0] d);
    logic [CMP_W-1:0] s;
    logic             carry;
    s     = CMP_W'(acc) + CMP_W'(r);
    carry = 1'b0;
    if (s >= CMP_W'(d)) begin
      s     = s - CMP_W'(d);
      carry = 1'b1;
    end
    if (s >= CMP_W'(d)) s = CMP_W'(d) - CMP_W'(1);
    return {carry, s[CNT_W-1:0]};
  endfunction

  assign tick.ready = !move.valid || move.ready;
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    c_out_col  = tick.restart ? '0 : out_col;
    c_out_row  = tick.restart ? '0 : out_row;
    c_col_rem  = tick.restart ? '0 : src_col_rem;
    c_row_rem  = tick.restart ? '0 : src_row_rem;
    c_chan     = tick.restart ? '0 : chan_count;
    c_src_col  = tick.restart ? '0 : src_col;
    c_row_base = tick.restart ? '0 : src_row_base;
    c_dst      = tick.restart ? '0 : dst_count;

    end_chan = (CHW'(c_chan) + CHW'(1)) >= eff.ch;
    end_col  = (CMP_W'(c_out_col) + CMP_W'(1)) >= CMP_W'(eff.ow);
    end_row  = (CMP_W'(c_out_row) + CMP_W'(1)) >= CMP_W'(eff.oh);

    x_add    = rem_add(c_col_rem, eff.xr, eff.ow);
    y_add    = rem_add(c_row_rem, eff.yr, eff.oh);
    // whole-row product hangs off the registers only; a carry adds one more row
    row_step = IW'(32'(eff.yw) * 32'(eff.iw)) + (y_add[CNT_W] ? IW'(eff.iw) : IW'(0));

    src_pix  = c_row_base + c_src_col;
    src_idx  = IW'(src_pix * IW'(eff.ch)) + IW'(c_chan);

    out_col_next      = c_out_col;
    out_row_next      = c_out_row;
    src_col_rem_next  = c_col_rem;
    src_row_rem_next  = c_row_rem;
    chan_count_next   = c_chan;
    src_col_next      = c_src_col;
    src_row_base_next = c_row_base;
    dst_count_next    = c_dst + IW'(1);

    priority if (!end_chan) begin
      chan_count_next = c_chan + CC_W'(1);
    end else if (!end_col) begin
      chan_count_next  = '0;
      out_col_next     = c_out_col + CNT_W'(1);
      src_col_next     = c_src_col + IW'(eff.xw) + IW'(x_add[CNT_W]);
      src_col_rem_next = x_add[CNT_W-1:0];
    end else if (!end_row) begin
      chan_count_next   = '0;
      out_col_next      = '0;
      src_col_next      = '0;
      src_col_rem_next  = '0;
      out_row_next      = c_out_row + CNT_W'(1);
      src_row_rem_next  = y_add[CNT_W-1:0];
      src_row_base_next = c_row_base + row_step;
    end else begin
      chan_count_next   = '0;
      out_col_next      = '0;
      out_row_next      = '0;
      src_col_next      = '0;
      src_col_rem_next  = '0;
      src_row_rem_next  = '0;
      src_row_base_next = '0;
      dst_count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_col      <= '0;
      out_row      <= '0;
      src_col_rem  <= '0;
      src_row_rem  <= '0;
      chan_count   <= '0;
      src_col      <= '0;
      src_row_base <= '0;
      dst_count    <= '0;
      move.valid   <= 1'b0;
    end else if (accept) begin
      out_col      <= out_col_next;
      out_row      <= out_row_next;
      src_col_rem  <= src_col_rem_next;
      src_row_rem  <= src_row_rem_next;
      chan_count   <= chan_count_next;
      src_col      <= src_col_next;
      src_row_base <= src_row_base_next;
      dst_count    <= dst_count_next;
      move.valid   <= 1'b1;
    end else if (move.ready) begin
      move.valid <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      move.src_addr      <= src_idx;
      move.dst_addr      <= c_dst;
      move.last_of_image <= end_chan && end_col && end_row;
    end
  end

endmodule
`default_nettype wire

### sv/nearest_neighbor_resize_addresser.sv
`default_nettype none
// Nearest-neighbour resize address generator. Each tick beat yields one move
// beat: a source byte index, a destination byte index and a last-of-image
// flag, walking the output image in raster order with the channel innermost.
// Source pixel for output (x, y) is (floor(x*in_w/out_w), floor(y*in_h/out_h)),
// stepped exactly from the whole/remainder registers, so they must be loaded
// with the quotient and remainder of the two ratios. A tick with restart set
// starts again at output byte zero; after the flagged last byte the walk wraps
// by itself. Throughput is one beat per clock while move drains; the move
// beat is registered, as the walk state and the move register update together
// on each accepted tick. A new tick is taken when move is empty or draining.
// The longest paths are the row step (remainder add and carry, then two adds
// into the row base; the whole-row product depends on the registers only) and
// the source index (pixel add, times channels, plus channel). Registers are
// written through the cfg channel, which is always ready; write them only
// while no beat is in flight.
module nearest_neighbor_resize_addresser #(
  parameter int MAX_DIM      = nnra_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = nnra_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  nnra_cfg_if.sink    cfg,
  nnra_tick_if.sink   tick,
  nnra_move_if.source move
);

  // clamped register view shared with the walker
  nnra_pkg::cfg_eff_t eff;

  nnra_cfg #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .eff (eff)
  );

  // position counters, index arithmetic and the move register
  nnra_walk #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .eff  (eff),
    .tick (tick),
    .move (move)
  );

endmodule
`default_nettype wire
